// ===== hdl/double_hash_table_assert.svh =====
// Assertion macros used by the hash table controller.
`ifndef DOUBLE_HASH_TABLE_ASSERT_SVH
`define DOUBLE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define DHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define DHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dht_pkg.sv =====
// Package of shared constants, codes and controller/datapath interface types.
package dht_pkg;

    localparam int TABLE_SLOTS_DEF  = 1021;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int KEY_W        = 31;
    localparam int IN_PAY_W     = 32;
    localparam int STATUS_W     = 2;
    localparam int SLOT_FIELD_W = 10;
    localparam int OUT_PAY_W    = 32;

    localparam int HASH_RADIX   = 4;
    localparam int HASH_GROUPS  = (KEY_W + HASH_RADIX - 1) / HASH_RADIX;
    localparam int KEY_PAD_W    = HASH_GROUPS * HASH_RADIX;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic    clr_step;
        logic    load;
        logic    hash_run;
        logic    probe_init;
        logic    rd_en;
        logic    probe_adv;
        logic    wr_en;
        logic    out_load;
        t_status res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic hash_done;
        logic is_lookup;
        logic slot_free;
        logic key_match;
        logic last_probe;
    } t_dp_sts;

endpackage

// ===== hdl/dht_hash.sv =====
// Iterative home-slot and probe-step unit: key mod N and key mod (N-2), radix-16.
module dht_hash #(
    parameter int TABLE_SLOTS = dht_pkg::TABLE_SLOTS_DEF,
    parameter int SLOT_W      = $clog2(TABLE_SLOTS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic                     i_run,
    input  logic [dht_pkg::KEY_W-1:0] i_key,
    output logic [SLOT_W-1:0]        o_home,
    output logic [SLOT_W-1:0]        o_step,
    output logic                     o_done
);

    localparam int CNT_W = $clog2(dht_pkg::HASH_GROUPS + 1);
    localparam logic [SLOT_W:0]   MOD_H  = (SLOT_W+1)'(TABLE_SLOTS);
    localparam logic [SLOT_W:0]   MOD_S  = (SLOT_W+1)'(TABLE_SLOTS - 2);
    localparam logic [SLOT_W-1:0] STEP_M = SLOT_W'(TABLE_SLOTS - 2);

    logic [dht_pkg::KEY_PAD_W-1:0] r_shift;
    logic [SLOT_W-1:0]             r_rem_h;
    logic [SLOT_W-1:0]             r_rem_s;
    logic [CNT_W-1:0]              r_cnt;

    logic [SLOT_W-1:0] n_rem_h;
    logic [SLOT_W-1:0] n_rem_s;
    logic [SLOT_W:0]   t_h;
    logic [SLOT_W:0]   t_s;

    always_comb begin
        n_rem_h = r_rem_h;
        n_rem_s = r_rem_s;
        t_h     = '0;
        t_s     = '0;
        for (int b = 0; b < dht_pkg::HASH_RADIX; b++) begin
            t_h = {n_rem_h, r_shift[dht_pkg::KEY_PAD_W-1-b]};
            if (t_h >= MOD_H) begin
                t_h = t_h - MOD_H;
            end
            n_rem_h = t_h[SLOT_W-1:0];
            t_s = {n_rem_s, r_shift[dht_pkg::KEY_PAD_W-1-b]};
            if (t_s >= MOD_S) begin
                t_s = t_s - MOD_S;
            end
            n_rem_s = t_s[SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= CNT_W'(dht_pkg::HASH_GROUPS);
        end else if (i_run && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_shift <= dht_pkg::KEY_PAD_W'(i_key);
            r_rem_h <= '0;
            r_rem_s <= '0;
        end else if (i_run && r_cnt != '0) begin
            r_shift <= r_shift << dht_pkg::HASH_RADIX;
            r_rem_h <= n_rem_h;
            r_rem_s <= n_rem_s;
        end
    end

    assign o_home = r_rem_h;
    assign o_step = STEP_M - r_rem_s;
    assign o_done = (r_cnt == '0);

endmodule

// ===== hdl/dht_datapath.sv =====
// Datapath: slot memory, probe position and step, clearing counter, result register.
module dht_datapath #(
    parameter int TABLE_SLOTS  = dht_pkg::TABLE_SLOTS_DEF,
    parameter int PAYLOAD_BITS = dht_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dht_pkg::t_dp_cmd                  i_cmd,
    output dht_pkg::t_dp_sts                  o_sts,
    input  logic                              i_operation,
    input  logic [dht_pkg::KEY_W-1:0]         i_key,
    input  logic [dht_pkg::IN_PAY_W-1:0]      i_payload,
    output logic [dht_pkg::STATUS_W-1:0]      o_status,
    output logic [dht_pkg::SLOT_FIELD_W-1:0]  o_slot,
    output logic [dht_pkg::OUT_PAY_W-1:0]     o_stored_payload
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int MEM_W  = 1 + dht_pkg::KEY_W + PAYLOAD_BITS;
    localparam logic [SLOT_W:0]   MOD_N = (SLOT_W+1)'(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] LAST  = SLOT_W'(TABLE_SLOTS - 1);

    logic [MEM_W-1:0] mem [TABLE_SLOTS];

    logic [SLOT_W-1:0]            r_clr_cnt;
    logic                         r_op;
    logic [dht_pkg::KEY_W-1:0]    r_key;
    logic [PAYLOAD_BITS-1:0]      r_pay;
    logic [SLOT_W-1:0]            r_pos;
    logic [SLOT_W-1:0]            r_step;
    logic [SLOT_W-1:0]            r_probe_cnt;
    logic [MEM_W-1:0]             r_rd_data;
    dht_pkg::t_status             r_out_status;
    logic [dht_pkg::SLOT_FIELD_W-1:0] r_out_slot;
    logic [dht_pkg::OUT_PAY_W-1:0]    r_out_pay;

    logic [SLOT_W-1:0]       home;
    logic [SLOT_W-1:0]       step;
    logic                    hash_done;
    logic [SLOT_W:0]         pos_sum;
    logic [SLOT_W-1:0]       n_pos;
    logic                    rd_used;
    logic [dht_pkg::KEY_W-1:0] rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic [PAYLOAD_BITS+dht_pkg::IN_PAY_W-1:0]     in_pay_ext;
    logic [SLOT_W+dht_pkg::SLOT_FIELD_W-1:0]       slot_ext;
    logic [PAYLOAD_BITS+dht_pkg::OUT_PAY_W-1:0]    rd_pay_ext;
    logic                    mem_we;
    logic [SLOT_W-1:0]       mem_wa;
    logic [MEM_W-1:0]        mem_wd;

    dht_hash #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_cmd.load),
        .i_run   (i_cmd.hash_run),
        .i_key   (i_key),
        .o_home  (home),
        .o_step  (step),
        .o_done  (hash_done)
    );

    assign in_pay_ext = {{PAYLOAD_BITS{1'b0}}, i_payload};
    assign rd_used    = r_rd_data[MEM_W-1];
    assign rd_key     = r_rd_data[PAYLOAD_BITS +: dht_pkg::KEY_W];
    assign rd_pay     = r_rd_data[PAYLOAD_BITS-1:0];
    assign slot_ext   = {{dht_pkg::SLOT_FIELD_W{1'b0}}, r_pos};
    assign rd_pay_ext = {{dht_pkg::OUT_PAY_W{1'b0}}, rd_pay};

    always_comb begin
        pos_sum = {1'b0, r_pos} + {1'b0, r_step};
        if (pos_sum >= MOD_N) begin
            pos_sum = pos_sum - MOD_N;
        end
        n_pos = pos_sum[SLOT_W-1:0];
    end

    always_comb begin
        mem_we = i_cmd.clr_step || i_cmd.wr_en;
        if (i_cmd.clr_step) begin
            mem_wa = r_clr_cnt;
            mem_wd = '0;
        end else begin
            mem_wa = r_pos;
            mem_wd = {1'b1, r_key, r_pay};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_step && r_clr_cnt != LAST) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_key <= i_key;
            r_pay <= in_pay_ext[PAYLOAD_BITS-1:0];
        end
        if (i_cmd.probe_init) begin
            r_pos       <= home;
            r_step      <= step;
            r_probe_cnt <= '0;
        end else if (i_cmd.probe_adv) begin
            r_pos       <= n_pos;
            r_probe_cnt <= r_probe_cnt + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.res_status;
            unique case (i_cmd.res_status)
                dht_pkg::ST_INSERTED: begin
                    r_out_slot <= slot_ext[dht_pkg::SLOT_FIELD_W-1:0];
                    r_out_pay  <= '0;
                end
                dht_pkg::ST_FOUND: begin
                    r_out_slot <= slot_ext[dht_pkg::SLOT_FIELD_W-1:0];
                    r_out_pay  <= rd_pay_ext[dht_pkg::OUT_PAY_W-1:0];
                end
                default: begin
                    r_out_slot <= '0;
                    r_out_pay  <= '0;
                end
            endcase
        end
    end

    always_comb begin
        o_sts.clr_last   = (r_clr_cnt == LAST);
        o_sts.hash_done  = hash_done;
        o_sts.is_lookup  = r_op;
        o_sts.slot_free  = !rd_used;
        o_sts.key_match  = (rd_key == r_key);
        o_sts.last_probe = (r_probe_cnt == LAST);
    end

    assign o_status         = r_out_status;
    assign o_slot           = r_out_slot;
    assign o_stored_payload = r_out_pay;

endmodule

// ===== hdl/dht_ctrl.sv =====
// Controller: clearing pass, hash, probe walk and result handshake sequencing.
`include "double_hash_table_assert.svh"

module dht_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  dht_pkg::t_dp_sts i_sts,
    output dht_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_READ  = 5'b01000,
        S_CHECK = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                if (i_sts.hash_done) begin
                    o_cmd.probe_init = 1'b1;
                    n_state          = S_READ;
                end else begin
                    o_cmd.hash_run = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                priority if (i_sts.slot_free) begin
                    if (out_free) begin
                        o_cmd.out_load = 1'b1;
                        n_state        = S_IDLE;
                        if (i_sts.is_lookup) begin
                            o_cmd.res_status = dht_pkg::ST_NOT_FOUND;
                        end else begin
                            o_cmd.wr_en      = 1'b1;
                            o_cmd.res_status = dht_pkg::ST_INSERTED;
                        end
                    end
                end else if (i_sts.is_lookup && i_sts.key_match) begin
                    if (out_free) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.res_status = dht_pkg::ST_FOUND;
                        n_state          = S_IDLE;
                    end
                end else if (i_sts.last_probe) begin
                    if (out_free) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.res_status = dht_pkg::ST_FULL;
                        n_state          = S_IDLE;
                    end
                end else begin
                    o_cmd.probe_adv = 1'b1;
                    n_state         = S_READ;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `DHT_ASSERT_NOW(a_write_free_insert, o_cmd.wr_en, i_sts.slot_free && !i_sts.is_lookup, "write to a used slot or on lookup")
    `DHT_ASSERT_NOW(a_no_result_overwrite, o_cmd.out_load, !r_out_valid || i_out_ready, "pending result overwritten")
    `DHT_ASSERT_NOW(a_walk_bounded, o_cmd.probe_adv, !i_sts.last_probe, "probe walk past table size")
    `DHT_ASSERT_NEXT(a_clear_once, r_state == S_IDLE, r_state != S_CLEAR, "clearing pass restarted")

endmodule

// ===== hdl/double_hash_table.sv =====
// Top level: open-addressing hash table with double hashing.
//
//  channel  | valid       | ready        | payload
//  ---------+-------------+--------------+-------------------------------------
//  input    | i_in_valid  | o_in_ready   | i_operation, i_key, i_payload
//  output   | o_out_valid | i_out_ready  | o_status, o_slot, o_stored_payload
//
// An item runs 8 radix-16 remainder steps, a step that loads the probe start and then
// 1 to TABLE_SLOTS probes, each a registered slot read and its check.
// After reset a clearing pass frees every slot and holds off input.
// One item is in work at a time; the next is accepted while a result waits, and a finished
// walk holds in its check cycle while the output register is still full.
module double_hash_table #(
    parameter int TABLE_SLOTS  = dht_pkg::TABLE_SLOTS_DEF,
    parameter int PAYLOAD_BITS = dht_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_operation,
    input  logic [dht_pkg::KEY_W-1:0]         i_key,
    input  logic [dht_pkg::IN_PAY_W-1:0]      i_payload,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [dht_pkg::STATUS_W-1:0]      o_status,
    output logic [dht_pkg::SLOT_FIELD_W-1:0]  o_slot,
    output logic [dht_pkg::OUT_PAY_W-1:0]     o_stored_payload
);

    dht_pkg::t_dp_cmd cmd;
    dht_pkg::t_dp_sts sts;

    dht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dht_datapath #(
        .TABLE_SLOTS  (TABLE_SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_operation      (i_operation),
        .i_key            (i_key),
        .i_payload        (i_payload),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_stored_payload (o_stored_payload)
    );

endmodule

// ===== verif/dht_tb_pkg.sv =====
// Scoreboard class with a behavioral hash table that predicts each answer of the block.
`timescale 1ns / 1ps
package dht_tb_pkg;
    import dht_pkg::*;

    localparam int unsigned SLOTS      = TABLE_SLOTS_DEF;
    localparam int unsigned STEP_MOD   = SLOTS - 2;
    localparam int          REPORT_MAX = 10;

    typedef struct {
        t_status                 status;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [OUT_PAY_W-1:0]    data;
    } answer_t;

    class table_scoreboard;
        bit                slot_used [SLOTS];
        bit [KEY_W-1:0]    slot_key  [SLOTS];
        bit [IN_PAY_W-1:0] slot_data [SLOTS];
        answer_t           pending_answers [$];
        int unsigned       used_count;
        int unsigned       mismatches;

        function new();
            used_count = 0;
            mismatches = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        function answer_t probe_table(bit lookup, bit [KEY_W-1:0] key,
                                      bit [IN_PAY_W-1:0] data);
            answer_t     ans;
            int unsigned pos;
            int unsigned stride;
            ans.status = ST_FULL;
            ans.slot   = '0;
            ans.data   = '0;
            pos        = key % SLOTS;
            stride     = STEP_MOD - (key % STEP_MOD);
            for (int p = 0; p < SLOTS; p++) begin
                if (!slot_used[pos]) begin
                    if (lookup) begin
                        ans.status = ST_NOT_FOUND;
                    end else begin
                        slot_used[pos] = 1'b1;
                        slot_key[pos]  = key;
                        slot_data[pos] = data;
                        used_count++;
                        ans.status = ST_INSERTED;
                        ans.slot   = SLOT_FIELD_W'(pos);
                    end
                    return ans;
                end
                if (lookup && slot_key[pos] == key) begin
                    ans.status = ST_FOUND;
                    ans.slot   = SLOT_FIELD_W'(pos);
                    ans.data   = slot_data[pos];
                    return ans;
                end
                pos = (pos + stride) % SLOTS;
            end
            return ans;
        endfunction

        function void note_request(bit lookup, bit [KEY_W-1:0] key, bit [IN_PAY_W-1:0] data);
            pending_answers.push_back(probe_table(lookup, key, data));
        endfunction

        function int unsigned waiting();
            return pending_answers.size();
        endfunction

        function void check_answer(logic [STATUS_W-1:0] status, logic [SLOT_FIELD_W-1:0] slot,
                                   logic [OUT_PAY_W-1:0] data);
            answer_t want;
            if (pending_answers.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected transaction: status %0d slot %0d payload %h",
                             status, slot, data);
                mismatches++;
                return;
            end
            want = pending_answers.pop_front();
            if (status !== want.status || slot !== want.slot || data !== want.data) begin
                if (mismatches < REPORT_MAX)
                    $display("mismatch: expected status %0d slot %0d payload %h, got %0d %0d %h",
                             want.status, want.slot, want.data, status, slot, data);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ===== verif/tb.sv =====
// Top-level testbench of the double hashing table: stimulus, handshakes and final check.
`timescale 1ns / 1ps
module tb;
    import dht_pkg::*;
    import dht_tb_pkg::*;

    localparam int          GAP_MAX      = 12;
    localparam int          BURST_MAX    = 16;
    localparam int          STALL_MAX    = 16;
    localparam int          HOLD_AFTER   = 60;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          RANDOM_ITEMS = 400;
    localparam int          FULL_ITEMS   = 50;
    localparam int          ITEM_BOUND   = 1600;
    localparam int          DRAIN_CYCLES = 2 * SLOTS + 16;
    localparam int unsigned CYCLE_LIMIT  =
        4 * ITEM_BOUND * (10 + 2 * SLOTS + GAP_MAX + STALL_MAX) + SLOTS + HOLD_CYCLES;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    i_operation = 1'b0;
    logic [KEY_W-1:0]        i_key       = '0;
    logic [IN_PAY_W-1:0]     i_payload   = '0;
    logic                    i_out_ready = 1'b0;
    logic                    o_in_ready;
    logic                    o_out_valid;
    logic [STATUS_W-1:0]     o_status;
    logic [SLOT_FIELD_W-1:0] o_slot;
    logic [OUT_PAY_W-1:0]    o_stored_payload;

    table_scoreboard  table_board;
    int unsigned      accepted_count = 0;
    int unsigned      burst_left     = 0;
    bit [KEY_W-1:0]   stored_keys [$];

    double_hash_table u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_key            (i_key),
        .i_payload        (i_payload),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_stored_payload (o_stored_payload)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            table_board.check_answer(o_status, o_slot, o_stored_payload);
    end

    task automatic send_item(input bit lookup, input bit [KEY_W-1:0] k,
                             input bit [IN_PAY_W-1:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, GAP_MAX));
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, BURST_MAX);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_operation = lookup;
        i_key       = k;
        i_payload   = d;
        do @(posedge i_clk); while (!o_in_ready);
        table_board.note_request(lookup, k, d);
        if (!lookup) stored_keys.push_back(k);
        accepted_count++;
    endtask

    task automatic random_item(input int insert_pct);
        bit                lookup;
        bit [KEY_W-1:0]    k;
        bit [IN_PAY_W-1:0] d;
        int                pick;
        lookup = ($urandom_range(0, 99) >= insert_pct);
        pick   = $urandom_range(0, 99);
        if (stored_keys.size() > 0 && lookup && pick < 55)
            k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        else if (stored_keys.size() > 0 && pick < 75)
            k = stored_keys[$urandom_range(0, stored_keys.size() - 1)]
                + KEY_W'(SLOTS * $urandom_range(0, 3));
        else if (pick < 85)
            k = KEY_W'($urandom_range(0, 4095));
        else
            k = KEY_W'($urandom());
        case ($urandom_range(0, 9))
            0: d = '0;
            1: d = '1;
            default: d = $urandom();
        endcase
        send_item(lookup, k, d);
    endtask

    // receiver: shifting stall patterns, with one long hold-off once HOLD_AFTER items are accepted
    initial begin
        int mode;
        int tick;
        bit held;
        mode = 0;
        tick = 0;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && accepted_count >= HOLD_AFTER) begin
                held        = 1'b1;
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (tick % 48 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: i_out_ready = 1'b1;
                1: i_out_ready = 1'($urandom_range(0, 1));
                2: i_out_ready = ($urandom_range(0, 7) != 0);
                default: i_out_ready = ((tick % 7) < 4);
            endcase
            tick++;
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        table_board = new();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(1'b1, KEY_W'(0), 32'h0);
        send_item(1'b0, KEY_W'(0), 32'h0);
        send_item(1'b0, '1, '1);
        send_item(1'b1, KEY_W'(0), '1);
        send_item(1'b1, '1, 32'h0);
        send_item(1'b0, KEY_W'(SLOTS), 32'hA5A5_A5A5);
        send_item(1'b1, KEY_W'(SLOTS), 32'h0);
        send_item(1'b1, KEY_W'(2 * SLOTS), 32'h0);
        send_item(1'b0, KEY_W'(5), 32'h1111_1111);
        send_item(1'b0, KEY_W'(5), 32'h2222_2222);
        send_item(1'b1, KEY_W'(5), 32'h0);
        send_item(1'b0, KEY_W'(STEP_MOD - 1), 32'h0F0F_0F0F);
        send_item(1'b0, KEY_W'(STEP_MOD), 32'hF0F0_F0F0);
        send_item(1'b0, KEY_W'(SLOTS - 1), 32'h5555_AAAA);
        send_item(1'b0, KEY_W'(2 * SLOTS - 1), 32'hAAAA_5555);
        send_item(1'b1, KEY_W'(2 * SLOTS - 1), '1);
        send_item(1'b1, KEY_W'(SLOTS - 1), 32'h0);
        send_item(1'b1, '1 - KEY_W'(SLOTS), 32'h0);

        repeat (RANDOM_ITEMS) random_item(55);
        while (table_board.used_count < SLOTS) random_item(85);

        // table is full from here on
        send_item(1'b0, KEY_W'(777), 32'hDEAD_BEEF);
        send_item(1'b1, KEY_W'(0), 32'h0);
        send_item(1'b1, '1 - KEY_W'(3), 32'h0);
        repeat (FULL_ITEMS) random_item(40);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (table_board.waiting() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (table_board.mismatches == 0 && table_board.waiting() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
